// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define AST_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger implies condition on the following edge
`define AST_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ===== sv/mhps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mhps_pkg;

    // store geometry
    localparam int DEPTH  = 32;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // width for child index compares, holds 2*pos+2
    localparam int CMP_W  = IDX_W + 2;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SORT   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [CMP_W-1:0] t_cmp;
    typedef logic signed [DATA_W-1:0] t_data;

endpackage

`default_nettype wire

// ===== sv/max_heap_priority_sorter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// insert: walks up one heap level at a time, moving each smaller parent down, then places the value
// remove maximum: latches the root, moves the last entry to the root and sifts it down, one shared compare unit
// sort: (n-1) root extractions, each moving the root to slot k and sifting down, then results out ascending
// one request in flight at a time; the single-read-port heap memory sets the pace
// reset clears the entry count, sequencer and output register; heap memory is not cleared

`include "assert_macros.svh"

module max_heap_priority_sorter
    import mhps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [DATA_W-1:0] i_s_tdata,   // [31:0] value
    input  wire logic [1:0]        i_s_tuser,   // [1:0] cmd
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [DATA_W-1:0]      o_m_tdata,   // [31:0] result_value
    output logic [1:0]             o_m_tuser,   // [1:0] status
    output logic                   o_m_tlast
);

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RESP    = 4'd1;
    localparam logic [3:0] S_UP_RD   = 4'd2;
    localparam logic [3:0] S_UP_CMP  = 4'd3;
    localparam logic [3:0] S_RM_TOP  = 4'd4;
    localparam logic [3:0] S_RM_LAST = 4'd5;
    localparam logic [3:0] S_DN_L    = 4'd6;
    localparam logic [3:0] S_DN_R    = 4'd7;
    localparam logic [3:0] S_DN_CMP  = 4'd8;
    localparam logic [3:0] S_SO_TOP  = 4'd9;
    localparam logic [3:0] S_SO_K    = 4'd10;
    localparam logic [3:0] S_SO_NEXT = 4'd11;
    localparam logic [3:0] S_SW_RD   = 4'd12;
    localparam logic [3:0] S_SW_OUT  = 4'd13;

    // heap memory
    t_data mem [DEPTH];
    t_data r_rd_data;
    logic  wr_en;
    t_idx  wr_addr;
    t_data wr_data;
    t_idx  rd_addr;

    // control and datapath registers
    logic [3:0] r_state, n_state;
    t_cnt  r_count, n_count;
    logic  r_sort, n_sort;
    t_idx  r_pos, n_pos;
    t_cnt  r_n, n_n;
    t_data r_val, n_val;
    t_data r_top, n_top;
    t_data r_best, n_best;
    t_idx  r_best_idx, n_best_idx;
    logic  r_best_gt, n_best_gt;
    t_idx  r_k, n_k;
    t_idx  r_j, n_j;
    t_cnt  r_ntot, n_ntot;
    t_data r_pend_val, n_pend_val;
    logic [1:0] r_pend_st, n_pend_st;
    logic  r_out_valid, n_out_valid;
    t_data r_out_data, n_out_data;
    logic [1:0] r_out_st, n_out_st;
    logic  r_out_last, n_out_last;

    logic  s_acc;
    logic  out_free;
    logic  dn_done;
    t_cmp  lchild;
    t_cmp  rchild;
    t_cmp  n_ext;
    t_idx  parent;
    logic  sw_last;

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign lchild   = {1'b0, r_pos, 1'b1};
    assign rchild   = lchild + t_cmp'(1);
    assign n_ext    = t_cmp'(r_n);
    assign parent   = t_idx'((r_pos - t_idx'(1)) >> 1);
    assign sw_last  = (t_cnt'(r_j) + t_cnt'(1)) == r_ntot;

    // memory ports, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // sequencer and shared compare unit
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sort      = r_sort;
        n_pos       = r_pos;
        n_n         = r_n;
        n_val       = r_val;
        n_top       = r_top;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_best_gt   = r_best_gt;
        n_k         = r_k;
        n_j         = r_j;
        n_ntot      = r_ntot;
        n_pend_val  = r_pend_val;
        n_pend_st   = r_pend_st;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_st    = r_out_st;
        n_out_last  = r_out_last;
        wr_en       = 1'b0;
        wr_addr     = r_pos;
        wr_data     = r_val;
        rd_addr     = r_j;
        dn_done     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    case (i_s_tuser)
                        CMD_INSERT: begin
                            if (r_count >= t_cnt'(DEPTH)) begin
                                n_pend_val = '0;
                                n_pend_st  = ST_FULL;
                                n_state    = S_RESP;
                            end else begin
                                n_pos   = r_count[IDX_W-1:0];
                                n_val   = t_data'(i_s_tdata);
                                n_state = S_UP_RD;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_pend_val = '0;
                                n_pend_st  = ST_EMPTY;
                                n_state    = S_RESP;
                            end else begin
                                rd_addr = '0;
                                n_sort  = 1'b0;
                                n_state = S_RM_TOP;
                            end
                        end
                        CMD_SORT: begin
                            if (r_count == '0) begin
                                n_pend_val = '0;
                                n_pend_st  = ST_EMPTY;
                                n_state    = S_RESP;
                            end else begin
                                n_ntot  = r_count;
                                n_count = '0;
                                n_sort  = 1'b1;
                                n_k     = t_idx'(r_count - t_cnt'(1));
                                n_j     = '0;
                                if (r_count == t_cnt'(1)) begin
                                    n_state = S_SW_RD;
                                end else begin
                                    rd_addr = '0;
                                    n_state = S_SO_TOP;
                                end
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // single result waits for a free output register
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_pend_val;
                    n_out_st    = r_pend_st;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            // sift up: read parent
            S_UP_RD: begin
                if (r_pos == '0) begin
                    wr_en      = 1'b1;
                    n_count    = r_count + t_cnt'(1);
                    n_pend_val = '0;
                    n_pend_st  = ST_OK;
                    n_state    = S_RESP;
                end else begin
                    rd_addr = parent;
                    n_state = S_UP_CMP;
                end
            end

            // sift up: move parent down or place value
            S_UP_CMP: begin
                if (r_val > r_rd_data) begin
                    wr_en   = 1'b1;
                    wr_data = r_rd_data;
                    n_pos   = parent;
                    n_state = S_UP_RD;
                end else begin
                    wr_en      = 1'b1;
                    n_count    = r_count + t_cnt'(1);
                    n_pend_val = '0;
                    n_pend_st  = ST_OK;
                    n_state    = S_RESP;
                end
            end

            // remove: latch root, fetch last entry
            S_RM_TOP: begin
                n_top   = r_rd_data;
                rd_addr = t_idx'(r_count - t_cnt'(1));
                n_count = r_count - t_cnt'(1);
                n_n     = r_count - t_cnt'(1);
                n_state = S_RM_LAST;
            end

            S_RM_LAST: begin
                n_val   = r_rd_data;
                n_pos   = '0;
                n_state = S_DN_L;
            end

            // sift down: fetch left child, or place value when there is none
            S_DN_L: begin
                if (lchild >= n_ext) begin
                    wr_en   = 1'b1;
                    dn_done = 1'b1;
                end else begin
                    rd_addr = lchild[IDX_W-1:0];
                    n_state = S_DN_R;
                end
            end

            // sift down: compare left child, fetch right child if present
            S_DN_R: begin
                n_best     = r_rd_data;
                n_best_idx = lchild[IDX_W-1:0];
                n_best_gt  = r_rd_data > r_val;
                if (rchild < n_ext) begin
                    rd_addr = rchild[IDX_W-1:0];
                    n_state = S_DN_CMP;
                end else if (r_rd_data > r_val) begin
                    wr_en   = 1'b1;
                    wr_data = r_rd_data;
                    n_pos   = lchild[IDX_W-1:0];
                    n_state = S_DN_L;
                end else begin
                    wr_en   = 1'b1;
                    dn_done = 1'b1;
                end
            end

            // sift down: pick larger child against held value
            S_DN_CMP: begin
                if (r_best_gt ? (r_rd_data > r_best) : (r_rd_data > r_val)) begin
                    wr_en   = 1'b1;
                    wr_data = r_rd_data;
                    n_pos   = rchild[IDX_W-1:0];
                    n_state = S_DN_L;
                end else if (r_best_gt) begin
                    wr_en   = 1'b1;
                    wr_data = r_best;
                    n_pos   = r_best_idx;
                    n_state = S_DN_L;
                end else begin
                    wr_en   = 1'b1;
                    dn_done = 1'b1;
                end
            end

            // sort: latch root, fetch entry k
            S_SO_TOP: begin
                n_top   = r_rd_data;
                rd_addr = r_k;
                n_state = S_SO_K;
            end

            // sort: root goes to slot k, entry k sifts down from root
            S_SO_K: begin
                wr_en   = 1'b1;
                wr_addr = r_k;
                wr_data = r_top;
                n_val   = r_rd_data;
                n_n     = t_cnt'(r_k);
                n_pos   = '0;
                n_state = S_DN_L;
            end

            S_SO_NEXT: begin
                if (r_k == t_idx'(1)) begin
                    n_j     = '0;
                    n_state = S_SW_RD;
                end else begin
                    n_k     = r_k - t_idx'(1);
                    rd_addr = '0;
                    n_state = S_SO_TOP;
                end
            end

            // output sweep, ascending
            S_SW_RD: begin
                n_state = S_SW_OUT;
            end

            S_SW_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rd_data;
                    n_out_st    = ST_OK;
                    n_out_last  = sw_last;
                    if (sw_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + t_idx'(1);
                        n_state = S_SW_RD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // end of a sift down
        if (dn_done) begin
            if (r_sort) begin
                n_state = S_SO_NEXT;
            end else begin
                n_pend_val = r_top;
                n_pend_st  = ST_OK;
                n_state    = S_RESP;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sort     <= n_sort;
        r_pos      <= n_pos;
        r_n        <= n_n;
        r_val      <= n_val;
        r_top      <= n_top;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_best_gt  <= n_best_gt;
        r_k        <= n_k;
        r_j        <= n_j;
        r_ntot     <= n_ntot;
        r_pend_val <= n_pend_val;
        r_pend_st  <= n_pend_st;
        r_out_data <= n_out_data;
        r_out_st   <= n_out_st;
        r_out_last <= n_out_last;
    end

    // ports
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_st;
    assign o_m_tlast  = r_out_last;

    // checks
    `AST_HOLDS(a_count_bound, i_clk, i_rst_n, r_count <= t_cnt'(DEPTH), "entry count over depth")
    `AST_HOLDS(a_sweep_range, i_clk, i_rst_n, (r_state != S_SW_OUT) || (t_cnt'(r_j) < r_ntot), "sweep index past sorted entries")
    `AST_NEXT(a_sort_clears, i_clk, i_rst_n, s_acc && (i_s_tuser == CMD_SORT), r_count == '0, "sort left entries in heap")

endmodule

`default_nettype wire

// ===== tb/heap_sort_checker.sv =====
`timescale 1ns / 1ps

module heap_sort_checker
    import mhps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire logic              i_s_tready,
    input  wire logic [DATA_W-1:0] i_s_tdata,   // [31:0] value
    input  wire logic [1:0]        i_s_tuser,   // [1:0] cmd
    input  wire logic              i_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire logic [DATA_W-1:0] i_m_tdata,   // [31:0] result_value
    input  wire logic [1:0]        i_m_tuser,   // [1:0] status
    input  wire logic              i_m_tlast,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        t_data      value;
        logic [1:0] status;
        logic       last;
    } heap_result_t;

    // shadow copy of the heap and its fill level
    t_data        heap_mem [DEPTH];
    int unsigned  n_entries;
    heap_result_t pending_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        n_entries    = 0;
    end

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= MAX_PRINTED) begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
    endtask

    function automatic void push_result(input t_data v, input logic [1:0] st, input logic lst);
        heap_result_t r;
        r.value  = v;
        r.status = st;
        r.last   = lst;
        pending_results.push_back(r);
    endfunction

    // move the entry at pos down until no child is larger
    function automatic void sift_down(input int unsigned start, input int unsigned n);
        int unsigned pos;
        int unsigned big;
        int unsigned lc;
        int unsigned rc;
        t_data       tmp;
        bit          done;
        pos  = start;
        done = 1'b0;
        while (!done) begin
            big = pos;
            lc  = 2 * pos + 1;
            rc  = 2 * pos + 2;
            if (lc < n && heap_mem[lc] > heap_mem[big]) big = lc;
            if (rc < n && heap_mem[rc] > heap_mem[big]) big = rc;
            if (big == pos) begin
                done = 1'b1;
            end else begin
                tmp           = heap_mem[pos];
                heap_mem[pos] = heap_mem[big];
                heap_mem[big] = tmp;
                pos           = big;
            end
        end
    endfunction

    // insert: walk up past every smaller parent
    function automatic void predict_insert(input t_data v);
        int unsigned pos;
        if (n_entries >= DEPTH) begin
            push_result('0, ST_FULL, 1'b1);
        end else begin
            pos = n_entries;
            while (pos > 0 && v > heap_mem[(pos - 1) / 2]) begin
                heap_mem[pos] = heap_mem[(pos - 1) / 2];
                pos           = (pos - 1) / 2;
            end
            heap_mem[pos] = v;
            n_entries++;
            push_result('0, ST_OK, 1'b1);
        end
    endfunction

    // remove maximum: last entry goes to the root, count shrinks, then sift down
    function automatic void predict_remove_max();
        t_data top;
        if (n_entries == 0) begin
            push_result('0, ST_EMPTY, 1'b1);
        end else begin
            top = heap_mem[0];
            n_entries--;
            heap_mem[0] = heap_mem[n_entries];
            sift_down(0, n_entries);
            push_result(top, ST_OK, 1'b1);
        end
    endfunction

    // heapsort in place, emit ascending, heap left empty
    function automatic void predict_sort();
        int unsigned n;
        int unsigned j;
        int unsigned k;
        t_data       tmp;
        n = n_entries;
        if (n == 0) begin
            push_result('0, ST_EMPTY, 1'b1);
        end else begin
            for (j = n / 2; j > 0; j--) sift_down(j - 1, n);
            for (k = n - 1; k >= 1; k--) begin
                tmp         = heap_mem[0];
                heap_mem[0] = heap_mem[k];
                heap_mem[k] = tmp;
                sift_down(0, k);
            end
            for (k = 0; k < n; k++) push_result(heap_mem[k], ST_OK, (k + 1 == n));
            n_entries = 0;
        end
    endfunction

    task automatic check_result(input t_data got_v, input logic [1:0] got_st,
                                input logic got_last);
        heap_result_t exp_r;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result value=%0d status=%0d last=%0b",
                                      got_v, got_st, got_last));
        end else begin
            exp_r = pending_results.pop_front();
            if (got_v !== exp_r.value)
                report_mismatch($sformatf("result value %0d, expected %0d",
                                          got_v, exp_r.value));
            if (got_st !== exp_r.status)
                report_mismatch($sformatf("status %0d, expected %0d", got_st, exp_r.status));
            if (got_last !== exp_r.last)
                report_mismatch($sformatf("last %0b, expected %0b", got_last, exp_r.last));
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            n_entries = 0;
            pending_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_result(i_m_tdata, i_m_tuser, i_m_tlast);
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    CMD_INSERT: predict_insert(i_s_tdata);
                    CMD_REMOVE: predict_remove_max();
                    CMD_SORT:   predict_sort();
                    default: ;  // unused code, no effect and no result
                endcase
            end
        end
        o_pending = pending_results.size();
    end

endmodule

// ===== tb/tb_max_heap_priority_sorter.sv =====
`timescale 1ns / 1ps

module tb_max_heap_priority_sorter;
    import mhps_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int CLK_PERIOD        = 20;
    localparam int RESET_CYCLES      = 10;
    localparam int CYCLE_LIMIT       = 4000000;
    localparam int PHASE_A_ITEMS     = 140;
    localparam int PHASE_B_ITEMS     = 260;
    localparam int TOTAL_ITEMS       = 360;
    localparam int LONG_STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES      = 200;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic [DATA_W-1:0] s_tdata;
    logic [1:0]        s_tuser;
    logic              m_tready;
    wire               s_tready;
    wire               m_tvalid;
    wire  [DATA_W-1:0] m_tdata;
    wire  [1:0]        m_tuser;
    wire               m_tlast;

    int fail_count;
    int pending;
    int src_idle_pct;
    int dst_idle_pct;
    int item_count;
    int cycle_count = 0;
    bit long_stall_req;

    max_heap_priority_sorter u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    heap_sort_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random back-pressure, or one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (long_stall_req) begin
                m_tready <= 1'b0;
                repeat (LONG_STALL_CYCLES - 1) @(negedge clk);
                long_stall_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    // one request, entered and left at a falling edge; tvalid stays high afterwards
    task automatic send_req(input logic [1:0] cmd, input logic [DATA_W-1:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        if (cmd != CMD_UNUSED) item_count++;
    endtask

    // sender pauses until every expected result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // extremes and small values for duplicates, otherwise full range
    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 7);
            3:       return -$urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // inserts with the odd remove, then removes and usually a sort
    task automatic run_burst();
        int n;
        int k;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, DEPTH) : $urandom_range(1, 8);
        repeat (n) begin
            send_req(CMD_INSERT, rand_value());
            if ($urandom_range(0, 5) == 0) send_req(CMD_REMOVE, $urandom);
        end
        k = $urandom_range(0, 3);
        repeat (k) send_req(CMD_REMOVE, $urandom);
        if ($urandom_range(0, 2) != 0) send_req(CMD_SORT, $urandom);
    endtask

    // empty the heap, fill past full, free one slot, refill, sort all
    task automatic run_fill();
        send_req(CMD_SORT, $urandom);
        repeat (DEPTH + $urandom_range(1, 2)) send_req(CMD_INSERT, rand_value());
        send_req(CMD_REMOVE, $urandom);
        send_req(CMD_INSERT, rand_value());
        send_req(CMD_INSERT, rand_value());
        send_req(CMD_SORT, $urandom);
    endtask

    task automatic run_random(input int target);
        int kind;
        while (item_count < target) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                run_burst();
            end else if (kind == 7) begin
                run_fill();
            end else begin
                // noise: any command, unused code included
                repeat ($urandom_range(3, 8)) send_req(2'($urandom_range(0, 3)), $urandom);
            end
        end
    endtask

    initial begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_INSERT;
        long_stall_req = 1'b0;
        item_count     = 0;
        src_idle_pct   = 32;
        dst_idle_pct   = 84;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty cases, ignored code, value extremes, single-entry sort
        send_req(CMD_REMOVE, 32'hFFFF_FFFF);
        send_req(CMD_SORT, 32'h0000_0000);
        send_req(CMD_UNUSED, 32'hFFFF_FFFF);
        send_req(CMD_INSERT, 32'h7FFF_FFFF);
        send_req(CMD_INSERT, 32'h8000_0000);
        send_req(CMD_INSERT, 32'h0000_0000);
        send_req(CMD_INSERT, 32'hFFFF_FFFF);
        send_req(CMD_INSERT, 32'h0000_0001);
        send_req(CMD_INSERT, 32'h7FFF_FFFF);
        send_req(CMD_INSERT, 32'h5555_5555);
        send_req(CMD_INSERT, 32'hAAAA_AAAA);
        send_req(CMD_REMOVE, 32'h0000_0000);
        send_req(CMD_REMOVE, 32'h0000_0000);
        send_req(CMD_SORT, 32'hFFFF_FFFF);
        send_req(CMD_INSERT, 32'h0000_0005);
        send_req(CMD_SORT, 32'h0000_0000);
        send_req(CMD_REMOVE, 32'h0000_0000);

        // phase a: slow receiver
        run_random(PHASE_A_ITEMS);
        wait_drained();

        // phase b: slow sender
        src_idle_pct = 84;
        dst_idle_pct = 32;
        run_random(PHASE_B_ITEMS);
        wait_drained();

        // phase c: no idling, starting with a long receiver hold-off
        src_idle_pct   = 0;
        dst_idle_pct   = 0;
        long_stall_req = 1'b1;
        repeat (12) send_req(CMD_INSERT, rand_value());
        send_req(CMD_SORT, $urandom);
        wait_drained();
        run_random(TOTAL_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/mhps_pkg.sv
sv/max_heap_priority_sorter.sv
tb/heap_sort_checker.sv
tb/tb_max_heap_priority_sorter.sv
